// ----- design/aptt_pkg.sv -----
// Package for the aligned periodic target timer.
// Holds shared constants, request codes and the divider request and response types.
// It depends on nothing else.
package aptt_pkg;

  localparam int unsigned DivW  = 64;
  localparam int unsigned DvsrW = 32;
  localparam int unsigned CntW  = $clog2(DivW);

  localparam logic [29:0] NsPerSec       = 30'd1000000000;
  localparam logic [31:0] PeriodResetVal = 32'd1000000;

  localparam logic [1:0] ReqStart   = 2'd0;
  localparam logic [1:0] ReqReached = 2'd1;
  localparam logic [1:0] ReqStop    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DivW-1:0]   dividend;
    logic [DvsrW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DvsrW-1:0]  rem;
  } div_rsp_t;

endpackage

// ----- design/aptt_div.sv -----
// Iterative restoring divider for the aligned periodic target timer.
// Produces one quotient bit per cycle; depends on aptt_pkg.
module aptt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  aptt_pkg::div_req_t req_i,
  output aptt_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [aptt_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [aptt_pkg::DivW-1:0]     quot_q, quot_d;
  logic [aptt_pkg::DvsrW-1:0]    rem_q, rem_d;
  logic [aptt_pkg::DvsrW-1:0]    dvsr_q, dvsr_d;
  logic [aptt_pkg::DvsrW:0]      shifted;
  logic [aptt_pkg::DvsrW:0]      diff;
  logic                          ge;

  always_comb begin
    shifted = {rem_q, quot_q[aptt_pkg::DivW-1]};
    diff    = shifted - {1'b0, dvsr_q};
    ge      = shifted >= {1'b0, dvsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    quot_d  = quot_q;
    rem_d   = rem_q;
    dvsr_d  = dvsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = aptt_pkg::CntW'(aptt_pkg::DivW - 1);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvsr_d = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[aptt_pkg::DivW-2:0], ge};
      rem_d  = ge ? diff[aptt_pkg::DvsrW-1:0] : shifted[aptt_pkg::DvsrW-1:0];
      cnt_d  = cnt_q - aptt_pkg::CntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvsr_q <= dvsr_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- design/aligned_periodic_target_timer_top.sv -----
// Top level of the aligned periodic target timer.
// Sequences a shared multiplier, a carry loop and the divider in aptt_div; depends on aptt_pkg.
//
// One word is taken at a time and the input stalls until its result is built and has passed
// the output stall. A stop or an ignored request goes straight to the output stage, a
// target-reached advances the target and compares it with the time, re-aligning it when the
// target has to be re-anchored, and a start always aligns. Alignment uses the bit-serial
// divider that reduces the 64-bit time modulo the period, and the nanosecond sum is
// normalised by a compare-and-subtract loop that carries one second out of the nanoseconds
// per step, at most five. The period register is written through the configuration
// channel, which is always ready.
module aligned_periodic_target_timer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] now_sec_i,
  input  logic [29:0] now_nsec_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        target_valid_o,
  output logic [31:0] target_sec_o,
  output logic [29:0] target_nsec_o,
  output logic        fire_frame_o,
  output logic        reanchored_o,
  output logic        is_running_o
);

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StMulN  = 12'b000000000010,
    StAddN  = 12'b000000000100,
    StAdv   = 12'b000000001000,
    StMulT  = 12'b000000010000,
    StAddT  = 12'b000000100000,
    StCmp   = 12'b000001000000,
    StAlign = 12'b000010000000,
    StNxt   = 12'b000100000000,
    StDivW  = 12'b001000000000,
    StOut   = 12'b010000000000,
    StNorm  = 12'b100000000000
  } state_e;

  typedef enum logic [1:0] {
    ModeAdv   = 2'b01,
    ModeFinal = 2'b10
  } mode_e;

  state_e      state_q, state_d;
  mode_e       mode_q, mode_d;
  logic [31:0] period_q;
  logic        armed_q, armed_d;
  logic [1:0]  req_q, req_d;
  logic [31:0] now_sec_q, now_sec_d;
  logic [29:0] now_nsec_q, now_nsec_d;
  logic [61:0] prod_q, prod_d;
  logic [62:0] now_ns_q, now_ns_d;
  logic [62:0] tns_q, tns_d;
  logic [32:0] nsum_q, nsum_d;
  logic [31:0] tsec_q, tsec_d;
  logic [29:0] tnsec_q, tnsec_d;
  logic        fire_q, fire_d;
  logic        re_q, re_d;
  logic        tvalid_q, tvalid_d;

  logic        out_valid_q, out_valid_d;
  logic        o_tvalid_q, o_tvalid_d;
  logic [31:0] o_tsec_q, o_tsec_d;
  logic [29:0] o_tnsec_q, o_tnsec_d;
  logic        o_fire_q, o_fire_d;
  logic        o_re_q, o_re_d;
  logic        o_run_q, o_run_d;

  logic [31:0] period_eff;
  logic [32:0] adv_sum;
  logic [31:0] mul_a;
  logic        in_take;
  logic        out_free;

  aptt_pkg::div_req_t div_req;
  aptt_pkg::div_rsp_t div_rsp;

  aptt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != StIdle;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;

  assign period_eff = (period_q == '0) ? 32'd1 : period_q;
  assign adv_sum    = {3'b000, tnsec_q} + {1'b0, period_eff};
  assign mul_a      = (state_q == StMulT) ? tsec_q : now_sec_q;

  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    armed_d     = armed_q;
    req_d       = req_q;
    now_sec_d   = now_sec_q;
    now_nsec_d  = now_nsec_q;
    prod_d      = prod_q;
    now_ns_d    = now_ns_q;
    tns_d       = tns_q;
    nsum_d      = nsum_q;
    tsec_d      = tsec_q;
    tnsec_d     = tnsec_q;
    fire_d      = fire_q;
    re_d        = re_q;
    tvalid_d    = tvalid_q;
    out_valid_d = out_valid_q && out_stall_i;
    o_tvalid_d  = o_tvalid_q;
    o_tsec_d    = o_tsec_q;
    o_tnsec_d   = o_tnsec_q;
    o_fire_d    = o_fire_q;
    o_re_d      = o_re_q;
    o_run_d     = o_run_q;
    div_req.start    = 1'b0;
    div_req.dividend = {1'b0, now_ns_q};
    div_req.divisor  = period_eff;

    unique case (state_q)
      StIdle: begin
        if (in_take) begin
          req_d      = req_type_i;
          now_sec_d  = now_sec_i;
          now_nsec_d = now_nsec_i;
          fire_d     = 1'b0;
          re_d       = 1'b0;
          tvalid_d   = 1'b0;
          case (req_type_i)
            aptt_pkg::ReqStart: begin
              armed_d  = 1'b1;
              tvalid_d = 1'b1;
              state_d  = StMulN;
            end
            aptt_pkg::ReqReached: begin
              if (armed_q) begin
                fire_d   = 1'b1;
                tvalid_d = 1'b1;
                state_d  = StAdv;
              end else begin
                state_d  = StOut;
              end
            end
            aptt_pkg::ReqStop: begin
              armed_d = 1'b0;
              state_d = StOut;
            end
            default: state_d = StOut;
          endcase
        end
      end
      StMulN: begin
        prod_d  = {30'd0, mul_a} * {32'd0, aptt_pkg::NsPerSec};
        state_d = StAddN;
      end
      StAddN: begin
        now_ns_d = {1'b0, prod_q} + {33'd0, now_nsec_q};
        state_d  = (req_q == aptt_pkg::ReqStart) ? StAlign : StCmp;
      end
      StAdv: begin
        nsum_d  = adv_sum;
        mode_d  = ModeAdv;
        state_d = StNorm;
      end
      StMulT: begin
        prod_d  = {30'd0, mul_a} * {32'd0, aptt_pkg::NsPerSec};
        state_d = StAddT;
      end
      StAddT: begin
        tns_d   = {1'b0, prod_q} + {33'd0, tnsec_q};
        state_d = StMulN;
      end
      StCmp: begin
        if (tns_q <= now_ns_q) begin
          re_d    = 1'b1;
          state_d = StAlign;
        end else begin
          state_d = StOut;
        end
      end
      StAlign: begin
        div_req.start = 1'b1;
        state_d       = StDivW;
      end
      StNxt: begin
        nsum_d  = {3'b000, now_nsec_q} + {1'b0, period_eff} - {1'b0, div_rsp.rem};
        tsec_d  = now_sec_q;
        mode_d  = ModeFinal;
        state_d = StNorm;
      end
      StDivW: begin
        if (div_rsp.done) begin
          state_d = StNxt;
        end
      end
      StNorm: begin
        if (nsum_q >= {3'b000, aptt_pkg::NsPerSec}) begin
          nsum_d = nsum_q - {3'b000, aptt_pkg::NsPerSec};
          tsec_d = tsec_q + 32'd1;
        end else begin
          tnsec_d = nsum_q[29:0];
          state_d = (mode_q == ModeAdv) ? StMulT : StOut;
        end
      end
      StOut: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          o_tvalid_d  = tvalid_q;
          o_tsec_d    = tsec_q;
          o_tnsec_d   = tnsec_q;
          o_fire_d    = fire_q;
          o_re_d      = re_q;
          o_run_d     = armed_q;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      mode_q      <= ModeAdv;
      period_q    <= aptt_pkg::PeriodResetVal;
      armed_q     <= 1'b0;
      tsec_q      <= '0;
      tnsec_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      armed_q     <= armed_d;
      tsec_q      <= tsec_d;
      tnsec_q     <= tnsec_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        period_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    now_sec_q  <= now_sec_d;
    now_nsec_q <= now_nsec_d;
    prod_q     <= prod_d;
    now_ns_q   <= now_ns_d;
    tns_q      <= tns_d;
    nsum_q     <= nsum_d;
    fire_q     <= fire_d;
    re_q       <= re_d;
    tvalid_q   <= tvalid_d;
    o_tvalid_q <= o_tvalid_d;
    o_tsec_q   <= o_tsec_d;
    o_tnsec_q  <= o_tnsec_d;
    o_fire_q   <= o_fire_d;
    o_re_q     <= o_re_d;
    o_run_q    <= o_run_d;
  end

  assign out_valid_o    = out_valid_q;
  assign target_valid_o = o_tvalid_q;
  assign target_sec_o   = o_tsec_q;
  assign target_nsec_o  = o_tnsec_q;
  assign fire_frame_o   = o_fire_q;
  assign reanchored_o   = o_re_q;
  assign is_running_o   = o_run_q;

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> in_stall_o)
    else $error("input not stalled after a word was taken");

  a_reanchor_needs_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reanchored_o |-> fire_frame_o && target_valid_o)
    else $error("re-anchor reported without a frame");

  a_target_implies_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_valid_o |-> is_running_o)
    else $error("target programmed while stopped");

  a_target_nsec_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && target_valid_o |-> target_nsec_o < aptt_pkg::NsPerSec)
    else $error("target nanoseconds out of range");

endmodule

// ----- dv/aligned_periodic_target_timer_top_test.sv -----
// Self-checking testbench for aligned_periodic_target_timer_top, built on aptt_pkg.
// A small tracker class predicts every result word from the accepted request words, and
// plain tasks drive the request, result and period channels, the first two with random idle cycles.
module aligned_periodic_target_timer_top_test;

  localparam logic [1:0] ReqUnused = 2'd3;
  localparam longint unsigned NsSec = 64'd1000000000;

  typedef struct packed {
    logic        tvalid;
    logic [31:0] tsec;
    logic [29:0] tnsec;
    logic        frame;
    logic        realign;
    logic        running;
  } target_word_t;

  class target_tracker;
    logic [31:0] period;
    logic [31:0] tgt_sec;
    logic [29:0] tgt_nsec;
    logic armed;
    target_word_t pending_targets[$];
    int mismatches;
    int realigns;
    int frames;
    int words;
    int ignored;

    function new();
      period = aptt_pkg::PeriodResetVal;
      tgt_sec = '0;
      tgt_nsec = '0;
      armed = 1'b0;
      mismatches = 0;
      realigns = 0;
      frames = 0;
      words = 0;
      ignored = 0;
    endfunction

    function longint unsigned eff_period();
      return (period == 32'd0) ? 64'd1 : {32'd0, period};
    endfunction

    function void align_after(logic [31:0] s, logic [29:0] ns);
      longint unsigned p, now_ns, nxt;
      p = eff_period();
      now_ns = {32'd0, s} * NsSec + {34'd0, ns};
      nxt = (now_ns / p + 64'd1) * p;
      tgt_sec = 32'(nxt / NsSec);
      tgt_nsec = 30'(nxt % NsSec);
    endfunction

    function void note_request(logic [1:0] req, logic [31:0] s, logic [29:0] ns);
      target_word_t w;
      longint unsigned sum, secw;
      longint a, b, c, d, diff;
      w = '0;
      words++;
      case (req)
        aptt_pkg::ReqStart: begin
          align_after(s, ns);
          armed = 1'b1;
          w.tvalid = 1'b1;
        end
        aptt_pkg::ReqReached: begin
          if (armed) begin
            sum = {34'd0, tgt_nsec} + eff_period();
            secw = {32'd0, tgt_sec} + sum / NsSec;
            tgt_sec = secw[31:0];
            tgt_nsec = 30'(sum % NsSec);
            a = {32'd0, tgt_sec};
            b = {32'd0, s};
            c = {34'd0, tgt_nsec};
            d = {34'd0, ns};
            diff = (a - b) * 64'sd1000000000 + (c - d);
            w.tvalid = 1'b1;
            w.frame = 1'b1;
            frames++;
            if (diff <= 0) begin
              align_after(s, ns);
              w.realign = 1'b1;
              realigns++;
            end
          end else begin
            ignored++;
          end
        end
        aptt_pkg::ReqStop: begin
          armed = 1'b0;
        end
        default: begin
          ignored++;
        end
      endcase
      w.tsec = tgt_sec;
      w.tnsec = tgt_nsec;
      w.running = armed;
      pending_targets.push_back(w);
    endfunction

    function void check_target(target_word_t got);
      target_word_t want;
      if (pending_targets.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word arrived with nothing outstanding: %p", $realtime, got);
        return;
      end
      want = pending_targets.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected valid %0b sec %0d nsec %0d frame %0b realign %0b run %0b",
                   want.tvalid, want.tsec, want.tnsec, want.frame, want.realign, want.running);
          $display("  actual   valid %0b sec %0d nsec %0d frame %0b realign %0b run %0b",
                   got.tvalid, got.tsec, got.tnsec, got.frame, got.realign, got.running);
        end
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  req_type_i = aptt_pkg::ReqStart;
  logic [31:0] now_sec_i = '0;
  logic [29:0] now_nsec_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        target_valid_o;
  logic [31:0] target_sec_o;
  logic [29:0] target_nsec_o;
  logic        fire_frame_o;
  logic        reanchored_o;
  logic        is_running_o;

  target_tracker tracker = new();
  int max_gap = 3;

  aligned_periodic_target_timer_top uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .now_sec_i      (now_sec_i),
    .now_nsec_i     (now_nsec_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .target_valid_o (target_valid_o),
    .target_sec_o   (target_sec_o),
    .target_nsec_o  (target_nsec_o),
    .fire_frame_o   (fire_frame_o),
    .reanchored_o   (reanchored_o),
    .is_running_o   (is_running_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_word(input logic [1:0] req, input logic [31:0] s, input logic [29:0] ns);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= req;
    now_sec_i <= s;
    now_nsec_i <= ns;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    tracker.note_request(req, s, ns);
  endtask

  task automatic set_period(input logic [31:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    tracker.period = v;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (tracker.pending_targets.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic random_word();
    int pick;
    longint unsigned t, p;
    logic [31:0] s;
    logic [29:0] ns;
    pick = $urandom_range(0, 99);
    s = $urandom;
    ns = 30'($urandom_range(0, 999999999));
    if ($urandom_range(0, 9) == 0) ns = 30'($urandom);
    if (tracker.armed && pick < 65) begin
      p = tracker.eff_period();
      t = {32'd0, tracker.tgt_sec} * NsSec + {34'd0, tracker.tgt_nsec};
      case ($urandom_range(0, 5))
        0, 1, 2: t = t + ({32'd0, $urandom} % p);
        3:       t = t + p + ({32'd0, $urandom} % (p * 64'd3));
        4:       t = t - ({32'd0, $urandom} % (t + 64'd1));
        default: t = t + ({$urandom, $urandom} % (p * 64'd1000));
      endcase
      s = 32'(t / NsSec);
      ns = 30'(t % NsSec);
      if (ns < 30'd73741823 && s != 32'd0 && $urandom_range(0, 7) == 0) begin
        s = s - 32'd1;
        ns = ns + 30'd1000000000;
      end
      send_word(aptt_pkg::ReqReached, s, ns);
    end else if (pick < 80) begin
      send_word((tracker.armed || pick < 60) ? aptt_pkg::ReqStart : aptt_pkg::ReqReached,
                s, ns);
    end else if (pick < 90) begin
      send_word(aptt_pkg::ReqStop, s, ns);
    end else if (pick < 95) begin
      send_word(ReqUnused, s, ns);
    end else begin
      send_word(aptt_pkg::ReqReached, s, ns);
    end
  endtask

  initial begin
    int hold;
    target_word_t got;
    forever begin
      hold = $urandom_range(0, max_gap);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      got = {target_valid_o, target_sec_o, target_nsec_o, fire_frame_o, reanchored_o,
             is_running_o};
      tracker.check_target(got);
    end
  end

  initial begin
    logic [31:0] periods[6];
    int goal;
    periods[0] = 32'd1;
    periods[1] = 32'd0;
    periods[2] = 32'hFFFFFFFF;
    periods[3] = 32'($urandom_range(2, 5000));
    periods[4] = $urandom;
    periods[5] = aptt_pkg::PeriodResetVal;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(aptt_pkg::ReqReached, 32'd0, 30'd0);
    send_word(aptt_pkg::ReqStop, 32'd0, 30'd0);
    send_word(ReqUnused, 32'hFFFFFFFF, 30'h3FFFFFFF);
    send_word(aptt_pkg::ReqStart, 32'd0, 30'd0);
    send_word(aptt_pkg::ReqReached, 32'd0, 30'd1000000);
    send_word(aptt_pkg::ReqReached, 32'd5, 30'd123);
    send_word(ReqUnused, 32'd0, 30'd0);
    send_word(aptt_pkg::ReqStart, 32'hFFFFFFFF, 30'd999999999);
    send_word(aptt_pkg::ReqReached, 32'hFFFFFFFF, 30'd999999999);
    send_word(aptt_pkg::ReqStart, 32'd0, 30'h3FFFFFFF);
    send_word(aptt_pkg::ReqReached, 32'd1, 30'd999999999);
    send_word(aptt_pkg::ReqStart, 32'd7, 30'd999999999);
    send_word(aptt_pkg::ReqStop, 32'd7, 30'd999999999);
    send_word(aptt_pkg::ReqReached, 32'd8, 30'd0);
    drain();

    foreach (periods[i]) begin
      max_gap = (i == 4) ? 0 : 3;
      set_period(periods[i]);
      send_word(aptt_pkg::ReqStart, $urandom, 30'($urandom_range(0, 999999999)));
      goal = tracker.words - tracker.ignored + 58;
      while (tracker.words - tracker.ignored < goal) random_word();
      drain();
    end

    $display("Sent %0d request words over six period settings plus reset default.",
             tracker.words);
    $display("Predicted %0d frame signals, %0d of them re-anchored; %0d mismatches.",
             tracker.frames, tracker.realigns, tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timeout with %0d result words outstanding.", tracker.pending_targets.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
